// ===== hw/rtl/tlsa_pkg.sv =====
package tlsa_pkg;

  // Shared divider geometry: widest dividend is the pulse accumulator,
  // widest divisor is the record length register.
  localparam int DVD_W = 24;
  localparam int DVS_W = 8;

  localparam int MAX_SECONDS_DEF = 63;
  localparam int SAMPLE_BITS_DEF = 10;

  // Channel slot handled by the sequencer; analog slots are 0..2.
  localparam logic [1:0] PULSE_IDX = 2'd3;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/tlsa_div.sv =====
module tlsa_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tlsa_pkg::div_req_t req,
  output tlsa_pkg::div_rsp_t rsp
);

  localparam int DVD_W = tlsa_pkg::DVD_W;
  localparam int DVS_W = tlsa_pkg::DVS_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;

  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // One restoring step per cycle: quotient bits shift in where dividend bits leave.
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DVS_W'(rem_sh - {1'b0, dvs_r}) : DVS_W'(rem_sh);
      dvd_nxt = {dvd_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start && cnt_r == CNT_W'(1)) |=> (done_r && !busy_r))
    else $error("divider missed its done pulse");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!busy_r && $past(busy_r)))
    else $error("divider done without a finished run");

endmodule

// ===== hw/rtl/two_level_sample_averager.sv =====
// Two-level sample averager.
// in_*: one transfer per second, in_tdata = {pulse_count, analog_sample_2,
// analog_sample_1, analog_sample_0} from the top bits down, in_tuser = minute_start.
// The samples and pulses are summed per second; on a minute_start transfer
// (counted first) each sum is divided by the second count and added to a
// minute accumulator. After minutes_per_record minutes one out_* transfer
// carries each accumulator divided by the record length, and all sums clear.
// cfg_wr_en/cfg_wr_data load minutes_per_record (0 acts as 1); write it idle.
// The divisions run one at a time on a shared 24-bit restoring divider
// (1 quotient bit per cycle); in_tready is low while a minute or record
// boundary is handled. The result sits in an output register; if the
// receiver stalls, the next item is still taken, and only the next record's
// divisions wait for the register to drain. Reset clears all sums, counters
// and the output valid, and sets minutes_per_record to 1.
module two_level_sample_averager #(
  parameter int MAX_SECONDS = tlsa_pkg::MAX_SECONDS_DEF,
  parameter int SAMPLE_BITS = tlsa_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] analog_sample_0, [19:10] analog_sample_1, [29:20] analog_sample_2,
  // [45:30] pulse_count, [47:46] zero
  input  logic [47:0] in_tdata,
  // [0] minute_start
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [9:0] average_0, [19:10] average_1, [29:20] average_2,
  // [45:30] average_pulses, [47:46] zero
  output logic [47:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int DVD_W = tlsa_pkg::DVD_W;
  localparam int DVS_W = tlsa_pkg::DVS_W;
  localparam int CNT_W = $clog2(MAX_SECONDS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SECONDS);
  // Sample mask and analog average ceiling are the same value.
  localparam logic [9:0] SMPL_MASK =
    (SAMPLE_BITS >= 10) ? 10'h3FF : 10'((1 << SAMPLE_BITS) - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MSTART = 5'b00010,
    S_MWAIT  = 5'b00100,
    S_RSTART = 5'b01000,
    S_RWAIT  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       mpr_r;
  logic [CNT_W-1:0] sec_cnt_r, sec_cnt_nxt;
  logic [15:0]      asum_r [3];
  logic [15:0]      asum_nxt [3];
  logic [21:0]      psum_r, psum_nxt;
  logic [7:0]       min_cnt_r, min_cnt_nxt;
  logic [17:0]      aacc_r [3];
  logic [17:0]      aacc_nxt [3];
  logic [23:0]      pacc_r, pacc_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [9:0]       avg_r [3];
  logic [9:0]       avg_nxt [3];
  logic [15:0]      avgp_r, avgp_nxt;

  tlsa_pkg::div_req_t div_req;
  tlsa_pkg::div_rsp_t div_rsp;

  logic             in_xfer;
  logic [9:0]       smp [3];
  logic [7:0]       rec_len;
  logic [7:0]       min_cnt_inc;
  logic [16:0]      asum_add [3];
  logic [22:0]      psum_add;
  logic [18:0]      aacc_add;
  logic [24:0]      pacc_add;

  tlsa_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign rec_len   = (mpr_r == 8'd0) ? 8'd1 : mpr_r;
  assign min_cnt_inc = (min_cnt_r == 8'hFF) ? min_cnt_r : min_cnt_r + 8'd1;

  assign smp[0] = in_tdata[9:0]   & SMPL_MASK;
  assign smp[1] = in_tdata[19:10] & SMPL_MASK;
  assign smp[2] = in_tdata[29:20] & SMPL_MASK;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      asum_add[i] = {1'b0, asum_r[i]} + 17'(smp[i]);
    end
    psum_add = {1'b0, psum_r} + 23'(in_tdata[45:30]);
    aacc_add = {1'b0, aacc_r[idx_r]} + 19'(div_rsp.quotient);
    pacc_add = {1'b0, pacc_r} + 25'(div_rsp.quotient);
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = rec_len;
    unique case (state_r)
      S_MSTART: begin
        div_req.start    = 1'b1;
        div_req.divisor  = DVS_W'(sec_cnt_r);
        div_req.dividend = (idx_r == tlsa_pkg::PULSE_IDX) ? DVD_W'(psum_r)
                                                         : DVD_W'(asum_r[idx_r]);
      end
      S_RSTART: begin
        div_req.start    = !out_valid_r;
        div_req.dividend = (idx_r == tlsa_pkg::PULSE_IDX) ? pacc_r
                                                         : DVD_W'(aacc_r[idx_r]);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sec_cnt_nxt   = sec_cnt_r;
    asum_nxt      = asum_r;
    psum_nxt      = psum_r;
    min_cnt_nxt   = min_cnt_r;
    aacc_nxt      = aacc_r;
    pacc_nxt      = pacc_r;
    idx_nxt       = idx_r;
    avg_nxt       = avg_r;
    avgp_nxt      = avgp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          for (int i = 0; i < 3; i++) begin
            asum_nxt[i] = asum_add[i][16] ? 16'hFFFF : asum_add[i][15:0];
          end
          psum_nxt    = psum_add[22] ? 22'h3FFFFF : psum_add[21:0];
          sec_cnt_nxt = (sec_cnt_r < CNT_MAX) ? sec_cnt_r + CNT_W'(1) : sec_cnt_r;
          if (in_tuser) begin
            idx_nxt   = '0;
            state_nxt = S_MSTART;
          end
        end
      end
      S_MSTART: state_nxt = S_MWAIT;
      S_MWAIT: begin
        if (div_rsp.done) begin
          if (idx_r == tlsa_pkg::PULSE_IDX) begin
            pacc_nxt    = pacc_add[24] ? 24'hFFFFFF : pacc_add[23:0];
            asum_nxt    = '{default: '0};
            psum_nxt    = '0;
            sec_cnt_nxt = '0;
            min_cnt_nxt = min_cnt_inc;
            idx_nxt     = '0;
            state_nxt   = (min_cnt_inc >= rec_len) ? S_RSTART : S_IDLE;
          end else begin
            aacc_nxt[idx_r] = aacc_add[18] ? 18'h3FFFF : aacc_add[17:0];
            idx_nxt         = idx_r + 2'd1;
            state_nxt       = S_MSTART;
          end
        end
      end
      S_RSTART: begin
        // hold until the previous record has left the output register
        if (!out_valid_r) begin
          state_nxt = S_RWAIT;
        end
      end
      S_RWAIT: begin
        if (div_rsp.done) begin
          if (idx_r == tlsa_pkg::PULSE_IDX) begin
            avgp_nxt      = (|div_rsp.quotient[23:16]) ? 16'hFFFF
                                                       : div_rsp.quotient[15:0];
            out_valid_nxt = 1'b1;
            aacc_nxt      = '{default: '0};
            pacc_nxt      = '0;
            min_cnt_nxt   = '0;
            idx_nxt       = '0;
            state_nxt     = S_IDLE;
          end else begin
            avg_nxt[idx_r] = (div_rsp.quotient > DVD_W'(SMPL_MASK)) ? SMPL_MASK
                                                                    : div_rsp.quotient[9:0];
            idx_nxt        = idx_r + 2'd1;
            state_nxt      = S_RSTART;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mpr_r       <= 8'd1;
      sec_cnt_r   <= '0;
      asum_r      <= '{default: '0};
      psum_r      <= '0;
      min_cnt_r   <= '0;
      aacc_r      <= '{default: '0};
      pacc_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        mpr_r <= cfg_wr_data;
      end
      sec_cnt_r   <= sec_cnt_nxt;
      asum_r      <= asum_nxt;
      psum_r      <= psum_nxt;
      min_cnt_r   <= min_cnt_nxt;
      aacc_r      <= aacc_nxt;
      pacc_r      <= pacc_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avg_r  <= avg_nxt;
    avgp_r <= avgp_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, avgp_r, avg_r[2], avg_r[1], avg_r[0]};

  a_plain_second: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_tuser) |=> (state_r == S_IDLE))
    else $error("plain second left the idle state");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_MWAIT || state_r == S_RWAIT))
    else $error("quotient arrived outside a wait state");

  a_record_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RSTART && out_valid_r && !out_tready) |=> (state_r == S_RSTART))
    else $error("record division started over a pending result");

  a_valid_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RWAIT && state_r == S_IDLE))
    else $error("result raised outside the last record quotient");

endmodule
